/* sv/surface_normal_stencil_core_assert.svh */
// assertion macros for the surface normal stencil checker
// no dependencies; included by the checker file only
`ifndef SURFACE_NORMAL_STENCIL_CORE_ASSERT_SVH
`define SURFACE_NORMAL_STENCIL_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SNS_ASSERT_NOW(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("surface normal stencil check failed");

// next-cycle implication, disabled in reset
`define SNS_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("surface normal stencil check failed");

`endif

/* sv/sns_pkg.sv */
// shared types and constants of the surface normal stencil
// no dependencies
package sns_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int MAX_DELTA_DEF  = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_WINDOW_DELTA = 2'd2
  } cfg_reg_t;

  localparam logic [10:0] WIDTH_RST  = 11'd640;
  localparam logic [10:0] HEIGHT_RST = 11'd480;
  localparam logic [2:0]  DELTA_RST  = 3'd1;

  localparam int MAG_W   = 31;
  localparam int QUOT_W  = 15;
  localparam logic [QUOT_W-1:0] Q_ONE = 15'd16384;

  typedef struct packed {
    logic signed [15:0] point_z;
    logic signed [15:0] point_y;
    logic signed [15:0] point_x;
  } point_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic [14:0]        normal_y;
    logic signed [15:0] normal_z;
    logic               normal_valid;
    logic [9:0]         centre_row;
    logic [9:0]         centre_col;
    logic               last_of_frame;
  } normal_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wr_data;
  } cfg_wr_t;

  typedef struct packed {
    logic [9:0] row;
    logic [9:0] col;
    logic       last;
    logic       ok;
    logic       sgn_x;
    logic       sgn_z;
  } meta_t;

  typedef struct packed {
    point_t a;
    point_t b;
    point_t c;
    point_t d;
  } corners_t;

  typedef logic [2:0][MAG_W-1:0] mag3_t;

endpackage

/* sv/sns_chan_if.sv */
// valid/ready channel carrying one item of type T
// no dependencies
interface sns_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/sns_window.sv */
// raster counters, line store memory and corner shift lines
// depends on sns_pkg
module sns_window #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_DELTA  = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  sns_pkg::point_t   in_pt,
  input  logic [10:0]       cfg_w,
  input  logic [10:0]       cfg_h,
  input  logic [2:0]        cfg_d,
  output logic              out_valid,
  output sns_pkg::corners_t out_crn,
  output sns_pkg::meta_t    out_meta
);
  import sns_pkg::*;

  localparam int ROWS  = 2 * MAX_DELTA + 1;
  localparam int DEPTH = ROWS * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(ROWS);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int DW    = $clog2(MAX_DELTA + 1);
  localparam int LW    = 2 * MAX_DELTA;
  localparam int LIW   = $clog2(LW);

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    return (s == SW'(ROWS - 1)) ? '0 : s + 1'b1;
  endfunction

  logic          acc;
  logic [31:0]   w32, h32, d32;
  logic [CW:0]   w_c;
  logic [RW:0]   h_c;
  logic [DW-1:0] d_c;
  logic [DW:0]   d2;
  logic [LIW-1:0] tap;

  logic [CW-1:0] col_r, col_nxt, c_e;
  logic [RW-1:0] row_r, row_nxt, r_e;
  logic [SW-1:0] slot_r, slot_nxt, sl_e, sl1, rslot;
  logic [RW:0]   r1, r2;
  logic [CW:0]   c1;
  logic          wrap_c, emit;
  logic [AW-1:0] waddr, raddr;
  meta_t         meta_e;

  point_t mem [DEPTH];
  point_t rd_q;
  point_t bline [LW];
  point_t aline [LW];

  logic   s1_valid_r;
  logic   s1_emit_r;
  point_t s1_d_r, s1_b_r;
  meta_t  s1_meta_r;

  assign acc = in_valid && adv;

  always_comb begin
    w32 = 32'(cfg_w);
    if (cfg_w == '0) w32 = 32'd1;
    else if (w32 > 32'(MAX_WIDTH)) w32 = 32'(MAX_WIDTH);
    h32 = 32'(cfg_h);
    if (cfg_h == '0) h32 = 32'd1;
    else if (h32 > 32'(MAX_HEIGHT)) h32 = 32'(MAX_HEIGHT);
    d32 = 32'(cfg_d);
    if (cfg_d == '0) d32 = 32'd1;
    else if (d32 > 32'(MAX_DELTA)) d32 = 32'(MAX_DELTA);
    w_c = (CW+1)'(w32);
    h_c = (RW+1)'(h32);
    d_c = DW'(d32);
    d2  = {d_c, 1'b0};
    tap = LIW'(32'(d2) - 32'd1);
  end

  // position of the arriving point, with the size checked first
  always_comb begin
    wrap_c = ({1'b0, col_r} >= w_c);
    c_e    = wrap_c ? '0 : col_r;
    r1     = wrap_c ? {1'b0, row_r} + 1'b1 : {1'b0, row_r};
    sl1    = wrap_c ? slot_inc(slot_r) : slot_r;
    if (r1 >= h_c) begin
      r_e  = '0;
      sl_e = '0;
    end else begin
      r_e  = RW'(r1);
      sl_e = sl1;
    end
    c1 = {1'b0, c_e} + 1'b1;
    r2 = {1'b0, r_e} + 1'b1;
    if (c1 >= w_c) begin
      col_nxt = '0;
      if (r2 >= h_c) begin
        row_nxt  = '0;
        slot_nxt = '0;
      end else begin
        row_nxt  = RW'(r2);
        slot_nxt = slot_inc(sl_e);
      end
    end else begin
      col_nxt  = CW'(c1);
      row_nxt  = r_e;
      slot_nxt = sl_e;
    end
    emit  = (32'(r_e) >= 32'(d2)) && (32'(c_e) >= 32'(d2));
    rslot = (32'(sl_e) >= 32'(d2)) ? SW'(32'(sl_e) - 32'(d2))
                                   : SW'(32'(sl_e) + 32'(ROWS) - 32'(d2));
    waddr = AW'(32'(sl_e) * 32'(MAX_WIDTH) + 32'(c_e));
    raddr = AW'(32'(rslot) * 32'(MAX_WIDTH) + 32'(c_e));
    meta_e.row   = 10'(32'(r_e) - 32'(d_c));
    meta_e.col   = 10'(32'(c_e) - 32'(d_c));
    meta_e.last  = (32'(r_e) == 32'(h_c) - 32'd1) && (32'(c_e) == 32'(w_c) - 32'd1);
    meta_e.ok    = 1'b0;
    meta_e.sgn_x = 1'b0;
    meta_e.sgn_z = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
    end else if (acc) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      slot_r <= slot_nxt;
    end
  end

  // line store: the corner row above is never the row being written
  always_ff @(posedge clk) begin
    if (acc) begin
      mem[waddr] <= in_pt;
      rd_q       <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      bline[0] <= in_pt;
      for (int k = 1; k < LW; k++) bline[k] <= bline[k-1];
      s1_d_r    <= in_pt;
      s1_b_r    <= bline[tap];
      s1_emit_r <= emit;
      s1_meta_r <= meta_e;
    end
    if (adv && s1_valid_r) begin
      aline[0] <= rd_q;
      for (int k = 1; k < LW; k++) aline[k] <= aline[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= acc;
    end
  end

  always_comb begin
    out_valid   = s1_valid_r && s1_emit_r;
    out_crn.a   = aline[tap];
    out_crn.b   = s1_b_r;
    out_crn.c   = rd_q;
    out_crn.d   = s1_d_r;
    out_meta    = s1_meta_r;
    out_meta.ok = (aline[tap] != '0) && (s1_b_r != '0) && (rd_q != '0) && (s1_d_r != '0);
  end

endmodule

/* sv/sns_calc.sv */
// difference vectors, cross product, sign flip, scaling and squared length
// depends on sns_pkg
module sns_calc (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  sns_pkg::corners_t in_crn,
  input  sns_pkg::meta_t    in_meta,
  output logic              out_valid,
  output sns_pkg::mag3_t    out_mag,
  output logic [63:0]       out_sum,
  output sns_pkg::meta_t    out_meta
);
  import sns_pkg::*;

  logic signed [15:0] ca [3], cb [3], cc [3], cd [3];

  logic [5:0] vld_r;

  logic signed [16:0] u_r [3], v_r [3];
  meta_t              m2_r;
  logic signed [33:0] p_r [6];
  meta_t              m3_r;
  logic signed [34:0] n_r [3];
  meta_t              m4_r;
  mag3_t              a5_r;
  meta_t              m5_r;
  logic [61:0]        sq_r [3];
  mag3_t              a6_r;
  meta_t              m6_r;
  logic [63:0]        s7_r;
  mag3_t              a7_r;
  meta_t              m7_r;

  logic signed [34:0] nf [3];
  logic [33:0]        m [3];
  logic [33:0]        mx;
  logic [1:0]         sh;
  logic               nz;
  mag3_t              a5;
  meta_t              m5;

  always_comb begin
    ca[0] = in_crn.a.point_x; ca[1] = in_crn.a.point_y; ca[2] = in_crn.a.point_z;
    cb[0] = in_crn.b.point_x; cb[1] = in_crn.b.point_y; cb[2] = in_crn.b.point_z;
    cc[0] = in_crn.c.point_x; cc[1] = in_crn.c.point_y; cc[2] = in_crn.c.point_z;
    cd[0] = in_crn.d.point_x; cd[1] = in_crn.d.point_y; cd[2] = in_crn.d.point_z;
  end

  // flip toward non-negative y, then shift magnitudes below 2^31
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nf[k] = n_r[1][34] ? -n_r[k] : n_r[k];
      m[k]  = nf[k][34] ? 34'(-nf[k]) : 34'(nf[k]);
    end
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
    if (mx[33:31] == '0) sh = 2'd0;
    else if (mx[33:32] == '0) sh = 2'd1;
    else if (!mx[33]) sh = 2'd2;
    else sh = 2'd3;
    for (int k = 0; k < 3; k++) a5[k] = MAG_W'(m[k] >> sh);
    nz       = (n_r[0] != '0) || (n_r[1] != '0) || (n_r[2] != '0);
    m5       = m4_r;
    m5.ok    = m4_r.ok && nz;
    m5.sgn_x = nf[0][34];
    m5.sgn_z = nf[2][34];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        u_r[k] <= {cb[k][15], cb[k]} - {cc[k][15], cc[k]};
        v_r[k] <= {ca[k][15], ca[k]} - {cd[k][15], cd[k]};
      end
      m2_r <= in_meta;

      p_r[0] <= v_r[1] * u_r[2];
      p_r[1] <= v_r[2] * u_r[1];
      p_r[2] <= v_r[2] * u_r[0];
      p_r[3] <= v_r[0] * u_r[2];
      p_r[4] <= v_r[0] * u_r[1];
      p_r[5] <= v_r[1] * u_r[0];
      m3_r   <= m2_r;

      n_r[0] <= {p_r[0][33], p_r[0]} - {p_r[1][33], p_r[1]};
      n_r[1] <= {p_r[2][33], p_r[2]} - {p_r[3][33], p_r[3]};
      n_r[2] <= {p_r[4][33], p_r[4]} - {p_r[5][33], p_r[5]};
      m4_r   <= m3_r;

      a5_r <= a5;
      m5_r <= m5;

      for (int k = 0; k < 3; k++) sq_r[k] <= a5_r[k] * a5_r[k];
      a6_r <= a5_r;
      m6_r <= m5_r;

      s7_r <= 64'(sq_r[0]) + 64'(sq_r[1]) + 64'(sq_r[2]);
      a7_r <= a6_r;
      m7_r <= m6_r;
    end
  end

  assign out_valid = vld_r[5];
  assign out_mag   = a7_r;
  assign out_sum   = s7_r;
  assign out_meta  = m7_r;

endmodule

/* sv/sns_isqrt.sv */
// pipelined integer square root, one result bit per stage
// depends on sns_pkg
module sns_isqrt (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_valid,
  input  logic [63:0]    in_sum,
  input  sns_pkg::mag3_t in_mag,
  input  sns_pkg::meta_t in_meta,
  output logic           out_valid,
  output logic [31:0]    out_root,
  output sns_pkg::mag3_t out_mag,
  output sns_pkg::meta_t out_meta
);
  import sns_pkg::*;

  localparam int STEPS = 32;

  typedef struct packed {
    meta_t       meta;
    mag3_t       mag;
    logic [63:0] rem;
    logic [63:0] root;
  } sq_stage_t;

  function automatic sq_stage_t sq_step(input sq_stage_t x, input int k);
    sq_stage_t   y;
    logic [63:0] b;
    logic [63:0] t;
    y = x;
    b = 64'd1 << (62 - 2 * k);
    t = x.root + b;
    if (x.rem >= t) begin
      y.rem  = x.rem - t;
      y.root = (x.root >> 1) + b;
    end else begin
      y.root = x.root >> 1;
    end
    return y;
  endfunction

  sq_stage_t      st_r [STEPS+1];
  logic [STEPS:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[STEPS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0].meta <= in_meta;
      st_r[0].mag  <= in_mag;
      st_r[0].rem  <= in_sum;
      st_r[0].root <= '0;
      for (int k = 0; k < STEPS; k++) st_r[k+1] <= sq_step(st_r[k], k);
    end
  end

  assign out_valid = vld_r[STEPS];
  assign out_root  = st_r[STEPS].root[31:0];
  assign out_mag   = st_r[STEPS].mag;
  assign out_meta  = st_r[STEPS].meta;

endmodule

/* sv/sns_divide.sv */
// pipelined rounding divide of three magnitudes by the length, result formatting
// depends on sns_pkg
module sns_divide (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_valid,
  input  logic [31:0]      in_len,
  input  sns_pkg::mag3_t   in_mag,
  input  sns_pkg::meta_t   in_meta,
  output logic             out_valid,
  output sns_pkg::normal_t out_nrm
);
  import sns_pkg::*;

  localparam int RMW = 47;

  typedef struct packed {
    meta_t                       meta;
    logic [2:0][RMW-1:0]         rem;
    logic [2:0][QUOT_W-1:0]      quo;
    logic [31:0]                 dvs;
  } dv_stage_t;

  function automatic dv_stage_t dv_step(input dv_stage_t x, input int j);
    dv_stage_t      y;
    logic [RMW-1:0] sh;
    y  = x;
    sh = RMW'(x.dvs) << j;
    for (int i = 0; i < 3; i++) begin
      if (x.rem[i] >= sh) begin
        y.rem[i]    = x.rem[i] - sh;
        y.quo[i][j] = 1'b1;
      end
    end
    return y;
  endfunction

  dv_stage_t       st_r [QUOT_W+1];
  logic [QUOT_W:0] vld_r;
  logic [QUOT_W-1:0] qs [3];
  dv_stage_t       lst;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[QUOT_W-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0].meta <= in_meta;
      st_r[0].dvs  <= (in_len == '0) ? 32'd1 : in_len;
      st_r[0].quo  <= '0;
      for (int i = 0; i < 3; i++) begin
        st_r[0].rem[i] <= RMW'({in_mag[i], 14'b0}) + RMW'(in_len >> 1);
      end
      for (int s = 0; s < QUOT_W; s++) st_r[s+1] <= dv_step(st_r[s], QUOT_W - 1 - s);
    end
  end

  always_comb begin
    lst = st_r[QUOT_W];
    for (int i = 0; i < 3; i++) qs[i] = (lst.quo[i] > Q_ONE) ? Q_ONE : lst.quo[i];
    out_nrm.normal_valid  = lst.meta.ok;
    out_nrm.centre_row    = lst.meta.row;
    out_nrm.centre_col    = lst.meta.col;
    out_nrm.last_of_frame = lst.meta.last;
    if (lst.meta.ok) begin
      out_nrm.normal_x = lst.meta.sgn_x ? -{1'b0, qs[0]} : {1'b0, qs[0]};
      out_nrm.normal_y = qs[1];
      out_nrm.normal_z = lst.meta.sgn_z ? -{1'b0, qs[2]} : {1'b0, qs[2]};
    end else begin
      out_nrm.normal_x = '0;
      out_nrm.normal_y = '0;
      out_nrm.normal_z = '0;
    end
  end

  assign out_valid = vld_r[QUOT_W];

endmodule

/* sv/surface_normal_stencil_core.sv */
// top level of the surface normal stencil: config registers, pipeline, output register
// depends on sns_pkg, sns_chan_if, sns_window, sns_calc, sns_isqrt, sns_divide
//
// channel  | role   | item
// in_pt    | sink   | point_t: point_x, point_y, point_z
// out_nrm  | source | normal_t: normal, valid flag, centre position, last of frame
// cfg_wr   | sink   | cfg_wr_t: register index, write data; always ready
//
// one point accepted per cycle while the pipeline is not held; the line store
// takes one write and one read for each accepted point; a result passes the window,
// calc, 32-step square root and 15-step divide pipelines and the output register
// reset clears counters and valid bits and loads the config defaults; the line store is not cleared
// while a result waits with out_nrm.ready low the whole pipeline holds
module surface_normal_stencil_core #(
  parameter int MAX_WIDTH  = sns_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sns_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_DELTA  = sns_pkg::MAX_DELTA_DEF
) (
  input logic        clk,
  input logic        rst_n,
  sns_chan_if.sink   in_pt,
  sns_chan_if.source out_nrm,
  sns_chan_if.sink   cfg_wr
);
  import sns_pkg::*;

  logic [10:0] cfg_w_r, cfg_h_r;
  logic [2:0]  cfg_d_r;
  logic        adv;

  logic     win_valid;
  corners_t win_crn;
  meta_t    win_meta;

  logic        calc_valid;
  mag3_t       calc_mag;
  logic [63:0] calc_sum;
  meta_t       calc_meta;

  logic        sq_valid;
  logic [31:0] sq_root;
  mag3_t       sq_mag;
  meta_t       sq_meta;

  logic    dv_valid;
  normal_t dv_nrm;

  logic    out_valid_r;
  normal_t out_data_r;

  assign adv          = !out_valid_r || out_nrm.ready;
  assign in_pt.ready  = adv;
  assign cfg_wr.ready = 1'b1;
  assign out_nrm.valid = out_valid_r;
  assign out_nrm.data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r <= WIDTH_RST;
      cfg_h_r <= HEIGHT_RST;
      cfg_d_r <= DELTA_RST;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.data.reg_index)
        CFG_IMAGE_WIDTH:  cfg_w_r <= cfg_wr.data.wr_data;
        CFG_IMAGE_HEIGHT: cfg_h_r <= cfg_wr.data.wr_data;
        CFG_WINDOW_DELTA: cfg_d_r <= cfg_wr.data.wr_data[2:0];
        default: ;
      endcase
    end
  end

  sns_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_DELTA  (MAX_DELTA)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_pt.valid),
    .in_pt     (in_pt.data),
    .cfg_w     (cfg_w_r),
    .cfg_h     (cfg_h_r),
    .cfg_d     (cfg_d_r),
    .out_valid (win_valid),
    .out_crn   (win_crn),
    .out_meta  (win_meta)
  );

  sns_calc u_calc (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (win_valid),
    .in_crn    (win_crn),
    .in_meta   (win_meta),
    .out_valid (calc_valid),
    .out_mag   (calc_mag),
    .out_sum   (calc_sum),
    .out_meta  (calc_meta)
  );

  sns_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (calc_valid),
    .in_sum    (calc_sum),
    .in_mag    (calc_mag),
    .in_meta   (calc_meta),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_mag   (sq_mag),
    .out_meta  (sq_meta)
  );

  sns_divide u_divide (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (sq_valid),
    .in_len    (sq_root),
    .in_mag    (sq_mag),
    .in_meta   (sq_meta),
    .out_valid (dv_valid),
    .out_nrm   (dv_nrm)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_data_r <= dv_nrm;
  end

endmodule

/* sv/sns_checker.sv */
// port-level checks of the surface normal stencil, bound to the top level
// depends on sns_pkg and surface_normal_stencil_core_assert.svh
`include "surface_normal_stencil_core_assert.svh"

module sns_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input sns_pkg::normal_t out_data,
  input logic             cfg_valid,
  input logic             cfg_ready
);
  import sns_pkg::*;

  `SNS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `SNS_ASSERT_NOW(a_in_open, clk, rst_n, !out_valid, in_ready)
  `SNS_ASSERT_NOW(a_bad_zero, clk, rst_n, out_valid && !out_data.normal_valid, out_data.normal_x == '0 && out_data.normal_y == '0 && out_data.normal_z == '0)
  `SNS_ASSERT_NOW(a_good_unit, clk, rst_n, out_valid && out_data.normal_valid, (out_data.normal_x != '0 || out_data.normal_y != '0 || out_data.normal_z != '0) && out_data.normal_y <= Q_ONE)
  `SNS_ASSERT_NOW(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready)

endmodule

bind surface_normal_stencil_core sns_checker u_sns_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_pt.ready),
  .out_valid (out_nrm.valid),
  .out_ready (out_nrm.ready),
  .out_data  (out_nrm.data),
  .cfg_valid (cfg_wr.valid),
  .cfg_ready (cfg_wr.ready)
);

/* tb/surface_normal_stencil_core_tb.sv */
// self-checking testbench for surface_normal_stencil_core: streams point cloud frames
// depends on sns_pkg, sns_chan_if and the core; predicts every normal and compares fields
`timescale 1ns / 100ps

module surface_normal_stencil_core_tb;
  import sns_pkg::*;

  localparam int STORE_ROWS  = 2 * MAX_DELTA_DEF + 1;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE      = 80;
  localparam int RAND_ITEMS  = 1950;

  logic clk;
  logic rst_n;

  sns_chan_if #(.T(point_t))  in_if ();
  sns_chan_if #(.T(normal_t)) out_if ();
  sns_chan_if #(.T(cfg_wr_t)) cfg_if ();

  surface_normal_stencil_core i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pt   (in_if),
    .out_nrm (out_if),
    .cfg_wr  (cfg_if)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // predictor state
  logic [47:0] pt_store [STORE_ROWS][MAX_WIDTH_DEF];
  int unsigned row_cnt, col_cnt;
  int unsigned img_w, img_h, win_d;

  point_t  point_q [$];
  normal_t normal_q [$];
  int      errors, n_items, n_normals, n_valid, n_phases;
  int      cycles;
  int      stall_mode;
  logic    took;
  int      gap_cnt, burst_cnt;

  function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint sext(logic [15:0] v);
    return longint'(signed'(v));
  endfunction

  task automatic predict_normal(input point_t p, output bit emit, output normal_t res);
    int unsigned w, h, d, r, c;
    logic [47:0] pa, pb, pc, pd;
    longint u [3], v [3], n [3], q [3];
    longint unsigned m [3], mx, s2, len, qq;
    int sh;
    bit ok;
    w = clamp_u(img_w, 1, MAX_WIDTH_DEF);
    h = clamp_u(img_h, 1, MAX_HEIGHT_DEF);
    d = clamp_u(win_d, 1, MAX_DELTA_DEF);
    emit = 0;
    res = '0;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (row_cnt >= h) row_cnt = 0;
    r = row_cnt;
    c = col_cnt;
    pt_store[r % STORE_ROWS][c] = {p.point_z, p.point_y, p.point_x};
    if (r >= 2 * d && c >= 2 * d) begin
      pa = pt_store[(r - 2 * d) % STORE_ROWS][c - 2 * d];
      pb = pt_store[r % STORE_ROWS][c - 2 * d];
      pc = pt_store[(r - 2 * d) % STORE_ROWS][c];
      pd = pt_store[r % STORE_ROWS][c];
      ok = pa != 0 && pb != 0 && pc != 0 && pd != 0;
      for (int k = 0; k < 3; k++) begin
        u[k] = sext(pb[16*k +: 16]) - sext(pc[16*k +: 16]);
        v[k] = sext(pa[16*k +: 16]) - sext(pd[16*k +: 16]);
        q[k] = 0;
      end
      n[0] = v[1] * u[2] - v[2] * u[1];
      n[1] = v[2] * u[0] - v[0] * u[2];
      n[2] = v[0] * u[1] - v[1] * u[0];
      if (n[0] == 0 && n[1] == 0 && n[2] == 0) ok = 0;
      if (ok) begin
        if (n[1] < 0) begin
          for (int k = 0; k < 3; k++) n[k] = -n[k];
        end
        mx = 0;
        for (int k = 0; k < 3; k++) begin
          m[k] = n[k] < 0 ? -n[k] : n[k];
          if (m[k] > mx) mx = m[k];
        end
        sh = 0;
        while ((mx >> sh) >= (64'd1 << 31)) sh++;
        s2 = 0;
        for (int k = 0; k < 3; k++) begin
          m[k] >>= sh;
          s2 += m[k] * m[k];
        end
        len = int_sqrt(s2);
        if (len == 0) len = 1;
        for (int k = 0; k < 3; k++) begin
          qq = (m[k] * 16384 + len / 2) / len;
          if (qq > 16384) qq = 16384;
          q[k] = n[k] < 0 ? -longint'(qq) : longint'(qq);
        end
      end
      res.normal_x      = q[0][15:0];
      res.normal_y      = q[1][14:0];
      res.normal_z      = q[2][15:0];
      res.normal_valid  = ok;
      res.centre_row    = 10'(r - d);
      res.centre_col    = 10'(c - d);
      res.last_of_frame = (r == h - 1 && c == w - 1);
      emit = 1;
    end
    col_cnt = c + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = r + 1;
      if (row_cnt >= h) row_cnt = 0;
    end
  endtask

  // input driver: bursts with random gaps, valid held until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
    end else begin
      if (took) void'(point_q.pop_front());
      if (!in_if.valid || took) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
          in_if.valid <= 1'b0;
        end else if (point_q.size() > 0) begin
          in_if.valid <= 1'b1;
          in_if.data  <= point_q[0];
          if (burst_cnt == 0) begin
            burst_cnt = $urandom_range(1, 40);
            gap_cnt   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_cnt--;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result receiver stall pattern
  always @(negedge clk) begin
    case (stall_mode)
      0: begin
        out_if.ready <= 1'b1;
      end
      1: begin
        out_if.ready <= $urandom_range(0, 1);
      end
      default: begin
        out_if.ready <= (cycles % 16) < 11;
      end
    endcase
  end

  // monitor: check results, then predict from the accepted item
  always @(posedge clk) begin
    normal_t got, exp_n;
    bit emit;
    took <= rst_n && in_if.valid && in_if.ready;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.data;
      n_normals++;
      if (got.normal_valid) n_valid++;
      if (normal_q.size() == 0) begin
        $error("unexpected normal at row %0d col %0d", got.centre_row, got.centre_col);
        errors++;
      end else begin
        exp_n = normal_q.pop_front();
        if (got.normal_x !== exp_n.normal_x) begin
          $error("normal_x: expected %0d, got %0d", exp_n.normal_x, got.normal_x);
          errors++;
        end
        if (got.normal_y !== exp_n.normal_y) begin
          $error("normal_y: expected %0d, got %0d", exp_n.normal_y, got.normal_y);
          errors++;
        end
        if (got.normal_z !== exp_n.normal_z) begin
          $error("normal_z: expected %0d, got %0d", exp_n.normal_z, got.normal_z);
          errors++;
        end
        if (got.normal_valid !== exp_n.normal_valid) begin
          $error("normal_valid: expected %0d, got %0d", exp_n.normal_valid, got.normal_valid);
          errors++;
        end
        if (got.centre_row !== exp_n.centre_row) begin
          $error("centre_row: expected %0d, got %0d", exp_n.centre_row, got.centre_row);
          errors++;
        end
        if (got.centre_col !== exp_n.centre_col) begin
          $error("centre_col: expected %0d, got %0d", exp_n.centre_col, got.centre_col);
          errors++;
        end
        if (got.last_of_frame !== exp_n.last_of_frame) begin
          $error("last_of_frame: expected %0d, got %0d",
                 exp_n.last_of_frame, got.last_of_frame);
          errors++;
        end
      end
    end
    if (rst_n && in_if.valid && in_if.ready) begin
      n_items++;
      predict_normal(in_if.data, emit, exp_n);
      if (emit) normal_q.insert(normal_q.size(), exp_n);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d normals outstanding", normal_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [10:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{reg_index: idx, wr_data: val};
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_IMAGE_WIDTH:  img_w = val;
      CFG_IMAGE_HEIGHT: img_h = val;
      default:          win_d = val[2:0];
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic drain();
    wait (point_q.size() == 0 && !in_if.valid && normal_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic point_t make_point(int style, int r, int c, int sx, int sy, int sz, int oz);
    point_t p;
    if ($urandom_range(0, 99) < 4) return '0;
    if (style == 0 || $urandom_range(0, 99) < 3) begin
      p = point_t'({$urandom, $urandom});
    end else if (style == 1) begin
      p.point_x = 16'(c * sx - 300);
      p.point_y = 16'(r * sy + 200);
      p.point_z = 16'(c * sz + r * sy / 2 + oz + $urandom_range(0, 3));
    end else begin
      p.point_x = 16'(sx);
      p.point_y = 16'(sy);
      p.point_z = 16'(oz);
    end
    return p;
  endfunction

  task automatic run_phase(logic [10:0] w, logic [10:0] h, logic [2:0] d, int frames);
    int ew, eh, style, sx, sy, sz, oz;
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_WINDOW_DELTA, d);
    stall_mode = $urandom_range(0, 2);
    ew = clamp_u(w, 1, MAX_WIDTH_DEF);
    eh = clamp_u(h, 1, MAX_HEIGHT_DEF);
    for (int f = 0; f < frames; f++) begin
      style = $urandom_range(0, 9) < 6 ? 1 : $urandom_range(0, 2);
      sx = $urandom_range(1, 900);
      sy = $urandom_range(1, 900);
      sz = int'($urandom_range(0, 1600)) - 800;
      oz = int'($urandom_range(0, 65535)) - 32768;
      for (int r = 0; r < eh; r++)
        for (int c = 0; c < ew; c++)
          point_q.insert(point_q.size(), make_point(style, r, c, sx, sy, sz, oz));
    end
    n_phases++;
    drain();
  endtask

  initial begin
    point_t p;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    took = 1'b0;
    errors = 0; n_items = 0; n_normals = 0; n_valid = 0; n_phases = 0;
    cycles = 0; gap_cnt = 0; burst_cnt = 0; stall_mode = 0;
    row_cnt = 0; col_cnt = 0;
    img_w = WIDTH_RST; img_h = HEIGHT_RST; win_d = DELTA_RST;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed 5x5 frame: field extremes, zero corner, flat patch, mixed corners
    write_reg(CFG_IMAGE_WIDTH, 11'd5);
    write_reg(CFG_IMAGE_HEIGHT, 11'd5);
    write_reg(CFG_WINDOW_DELTA, 3'd1);
    for (int i = 0; i < 25; i++) begin
      case (i)
        0:       p = '{point_z: -16'sd32768, point_y: -16'sd32768, point_x: -16'sd32768};
        2:       p = '{point_z: 16'sd32767, point_y: 16'sd32767, point_x: 16'sd32767};
        10:      p = '{point_z: 16'sd32767, point_y: -16'sd32768, point_x: 16'sd32767};
        12:      p = '{point_z: -16'sd32768, point_y: 16'sd32767, point_x: -16'sd32768};
        6:       p = '0;
        4, 14:   p = '{point_z: 16'sd1, point_y: -16'sd1, point_x: 16'sd0};
        default: p = (i >= 18) ? '{point_z: 16'sd500, point_y: 16'sd7, point_x: -16'sd9}
                               : point_t'({$urandom, $urandom});
      endcase
      point_q.insert(point_q.size(), p);
    end
    drain();

    // extremes of the registers, including out-of-range values
    run_phase(11'd2047, 11'd1, 3'd0, 1);
    run_phase(11'd0, 11'd0, 3'd1, 2);
    run_phase(11'd9, 11'd9, 3'd4, 2);
    run_phase(11'd8, 11'd12, 3'd7, 1);
    run_phase(11'd3, 11'd3, 3'd1, 3);

    while (n_items < RAND_ITEMS) begin
      run_phase(11'($urandom_range(1, 16)), 11'($urandom_range(1, 12)),
                3'($urandom_range(0, 9) < 8 ? $urandom_range(1, 4) : $urandom_range(0, 7)),
                $urandom_range(1, 2));
    end

    $display("%0d points in %0d configurations, %0d normals checked (%0d valid)",
             n_items, n_phases, n_normals, n_valid);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
